[rtl/assert_macros.svh]
// Assertion macros used by the top level of the 3x3 solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define LSV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every clock edge, reset included.
`define LSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/lsv_pkg.sv]
// Package with types and constants for the 3x3 linear system solver.
package lsv_pkg;

  localparam int IN_W   = 16;
  localparam int PROD_W = 32;
  localparam int CF_W   = 33;
  localparam int DP_W   = 49;
  localparam int SUM_W  = 50;
  localparam int FRAC_W = 16;
  localparam int Q_W    = 32;
  localparam int DIM    = 3;

  typedef struct packed {
    logic signed [IN_W-1:0] a11;
    logic signed [IN_W-1:0] a12;
    logic signed [IN_W-1:0] a13;
    logic signed [IN_W-1:0] a21;
    logic signed [IN_W-1:0] a22;
    logic signed [IN_W-1:0] a23;
    logic signed [IN_W-1:0] a31;
    logic signed [IN_W-1:0] a32;
    logic signed [IN_W-1:0] a33;
    logic signed [IN_W-1:0] b1;
    logic signed [IN_W-1:0] b2;
    logic signed [IN_W-1:0] b3;
  } req_t;

  typedef struct packed {
    logic signed [Q_W-1:0] x_value;
    logic signed [Q_W-1:0] y_value;
    logic signed [Q_W-1:0] z_value;
    logic                  singular;
  } rsp_t;

  // Pipeline control handed from the top level to each datapath section.
  typedef struct packed {
    logic en;
    logic rst;
  } pipe_ctl_t;

endpackage

[rtl/lsv_req_if.sv]
// Request channel carrying one 3x3 system with valid/ready handshake.
interface lsv_req_if;
  import lsv_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/lsv_rsp_if.sv]
// Response channel carrying one solution with valid/ready handshake.
interface lsv_rsp_if;
  import lsv_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/lsv_front.sv]
// Four-stage front end: cofactors, determinant and adjugate-times-b sums.
module lsv_front (
  input  logic                              clk,
  input  lsv_pkg::pipe_ctl_t                ctl,
  input  logic                              in_valid,
  input  lsv_pkg::req_t                     in_data,
  output logic                              out_valid,
  output logic signed [lsv_pkg::SUM_W-1:0]  det,
  output logic signed [lsv_pkg::SUM_W-1:0]  num [lsv_pkg::DIM]
);
  import lsv_pkg::*;

  logic signed [IN_W-1:0]   m [DIM][DIM];
  logic signed [IN_W-1:0]   bv [DIM];
  logic signed [PROD_W-1:0] pr0 [DIM][DIM];
  logic signed [PROD_W-1:0] pr1 [DIM][DIM];
  logic signed [IN_W-1:0]   m0_s1 [DIM];
  logic signed [IN_W-1:0]   b_s1 [DIM];
  logic signed [CF_W-1:0]   cof [DIM][DIM];
  logic signed [IN_W-1:0]   m0_s2 [DIM];
  logic signed [IN_W-1:0]   b_s2 [DIM];
  logic signed [DP_W-1:0]   dp [DIM];
  logic signed [DP_W-1:0]   np [DIM][DIM];
  logic [3:0]               vld;

  always_comb begin
    m[0][0] = in_data.a11; m[0][1] = in_data.a12; m[0][2] = in_data.a13;
    m[1][0] = in_data.a21; m[1][1] = in_data.a22; m[1][2] = in_data.a23;
    m[2][0] = in_data.a31; m[2][1] = in_data.a32; m[2][2] = in_data.a33;
    bv[0] = in_data.b1; bv[1] = in_data.b2; bv[2] = in_data.b3;
  end

  always_ff @(posedge clk) begin
    if (ctl.rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      // Stage 1: the two products of every 2x2 minor.
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          pr0[i][j] <= m[(i == 0) ? 1 : 0][(j == 0) ? 1 : 0]
                     * m[(i == 2) ? 1 : 2][(j == 2) ? 1 : 2];
          pr1[i][j] <= m[(i == 0) ? 1 : 0][(j == 2) ? 1 : 2]
                     * m[(i == 2) ? 1 : 2][(j == 0) ? 1 : 0];
        end
        m0_s1[i] <= m[0][i];
        b_s1[i]  <= bv[i];
      end
      // Stage 2: signed cofactors.
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          if (((i + j) % 2) == 1) begin
            cof[i][j] <= CF_W'(pr1[i][j]) - CF_W'(pr0[i][j]);
          end else begin
            cof[i][j] <= CF_W'(pr0[i][j]) - CF_W'(pr1[i][j]);
          end
        end
        m0_s2[i] <= m0_s1[i];
        b_s2[i]  <= b_s1[i];
      end
      // Stage 3: determinant terms and adjugate-times-b terms.
      for (int i = 0; i < DIM; i++) begin
        dp[i] <= DP_W'(m0_s2[i]) * DP_W'(cof[0][i]);
        for (int j = 0; j < DIM; j++) begin
          np[i][j] <= DP_W'(cof[j][i]) * DP_W'(b_s2[j]);
        end
      end
      // Stage 4: sums.
      det <= SUM_W'(dp[0]) + SUM_W'(dp[1]) + SUM_W'(dp[2]);
      for (int i = 0; i < DIM; i++) begin
        num[i] <= SUM_W'(np[i][0]) + SUM_W'(np[i][1]) + SUM_W'(np[i][2]);
      end
    end
  end

  assign out_valid = vld[3];

endmodule

[rtl/lsv_div.sv]
// One lane of the pipelined restoring divider with sign and saturation.
module lsv_div (
  input  logic                              clk,
  input  lsv_pkg::pipe_ctl_t                ctl,
  input  logic                              in_valid,
  input  logic signed [lsv_pkg::SUM_W-1:0]  num,
  input  logic signed [lsv_pkg::SUM_W-1:0]  det,
  output logic                              out_valid,
  output logic signed [lsv_pkg::Q_W-1:0]    quot,
  output logic                              zero
);
  import lsv_pkg::*;

  localparam int STEPS = Q_W;

  logic [SUM_W-1:0] un;
  logic [SUM_W-1:0] ud;
  logic [SUM_W-1:0] rem  [STEPS+1];
  logic [Q_W-1:0]   low  [STEPS+1];
  logic [Q_W-1:0]   q    [STEPS+1];
  logic [SUM_W-1:0] dv   [STEPS+1];
  logic             neg  [STEPS+1];
  logic             sat  [STEPS+1];
  logic             zr   [STEPS+1];
  logic [STEPS+1:0] vld;

  always_comb begin
    un = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    ud = det[SUM_W-1] ? SUM_W'(-det) : SUM_W'(det);
  end

  always_ff @(posedge clk) begin
    if (ctl.rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[STEPS:0], in_valid};
    end
  end

  // Setup: magnitudes, sign, zero-determinant flag, and the check for a quotient of 2^32 or more.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem[0] <= un >> FRAC_W;
      low[0] <= {un[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
      q[0]   <= '0;
      dv[0]  <= ud;
      neg[0] <= num[SUM_W-1] ^ det[SUM_W-1];
      sat[0] <= {FRAC_W'(0), un} >= {ud, FRAC_W'(0)};
      zr[0]  <= (det == '0);
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [SUM_W:0] t;
    logic [SUM_W:0] d;
    logic           ge;
    always_comb begin
      t  = {rem[k], low[k][Q_W-1]};
      d  = t - {1'b0, dv[k]};
      ge = (t >= {1'b0, dv[k]});
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[k+1] <= ge ? d[SUM_W-1:0] : t[SUM_W-1:0];
        low[k+1] <= {low[k][Q_W-2:0], 1'b0};
        q[k+1]   <= {q[k][Q_W-2:0], ge};
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
        sat[k+1] <= sat[k];
        zr[k+1]  <= zr[k];
      end
    end
  end

  // Final: force zero for a zero determinant, else apply sign and clamp to the signed 32-bit range.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      zero <= zr[STEPS];
      if (zr[STEPS]) begin
        quot <= '0;
      end else if (neg[STEPS]) begin
        if (sat[STEPS] || (q[STEPS][Q_W-1] && (|q[STEPS][Q_W-2:0]))) begin
          quot <= {1'b1, {(Q_W-1){1'b0}}};
        end else begin
          quot <= -q[STEPS];
        end
      end else begin
        if (sat[STEPS] || q[STEPS][Q_W-1]) begin
          quot <= {1'b0, {(Q_W-1){1'b1}}};
        end else begin
          quot <= q[STEPS];
        end
      end
    end
  end

  assign out_valid = vld[STEPS+1];

endmodule

[rtl/linear_solve_3x3_core.sv]
// Top level of the pipelined 3x3 linear system solver.
//
//   channel | dir | payload                                 | handshake
//   req     | in  | a11..a33, b1..b3, signed Q8.8           | valid/ready
//   rsp     | out | x_value, y_value, z_value Q16.16, singular | valid/ready
//
// One system enters per clock while the pipeline is not frozen, and its solution
// passes through the cofactor and sum section, the divider setup, the
// one-bit-per-stage divider lanes and the clamp.
// Reset is synchronous and clears only the valid bits of every stage.
// When the output holds an unaccepted result, the whole pipeline freezes,
// so nothing is dropped or repeated; otherwise it moves every cycle.
module linear_solve_3x3_core (
  input  logic       clk,
  input  logic       rst,
  lsv_req_if.sink    req,
  lsv_rsp_if.source  rsp
);
  import lsv_pkg::*;
  `include "assert_macros.svh"

  pipe_ctl_t                ctl;
  logic                     front_valid;
  logic signed [SUM_W-1:0]  det;
  logic signed [SUM_W-1:0]  num [DIM];
  logic                     lane_valid [DIM];
  logic signed [Q_W-1:0]    lane_quot [DIM];
  logic                     lane_zero [DIM];
  logic                     out_zeroed;
  logic                     sing_ok;
  logic                     lanes_ok;

  // The pipeline advances whenever the output register is empty or drained.
  assign ctl.en  = !rsp.valid || rsp.ready;
  assign ctl.rst = rst;
  assign req.ready = ctl.en;

  lsv_front u_front (
    .clk       (clk),
    .ctl       (ctl),
    .in_valid  (req.valid),
    .in_data   (req.data),
    .out_valid (front_valid),
    .det       (det),
    .num       (num)
  );

  // One divider lane per unknown; all three share the determinant.
  for (genvar i = 0; i < DIM; i++) begin : g_lane
    lsv_div u_div (
      .clk       (clk),
      .ctl       (ctl),
      .in_valid  (front_valid),
      .num       (num[i]),
      .det       (det),
      .out_valid (lane_valid[i]),
      .quot      (lane_quot[i]),
      .zero      (lane_zero[i])
    );
  end

  assign rsp.valid         = lane_valid[0];
  assign rsp.data.x_value  = lane_quot[0];
  assign rsp.data.y_value  = lane_quot[1];
  assign rsp.data.z_value  = lane_quot[2];
  assign rsp.data.singular = lane_zero[0];

  // A singular result must carry three zero unknowns.
  assign out_zeroed = (rsp.data.x_value == '0) && (rsp.data.y_value == '0)
                   && (rsp.data.z_value == '0);
  assign sing_ok = !rsp.valid || !rsp.data.singular || out_zeroed;

  // The lanes move in lockstep; their flags only mean something while valid.
  assign lanes_ok = (lane_valid[0] == lane_valid[1]) && (lane_valid[1] == lane_valid[2])
                 && (!lane_valid[0] || ((lane_zero[0] == lane_zero[1])
                 && (lane_zero[1] == lane_zero[2])));

  `LSV_ASSERT(a_singular_zero, clk, rst, sing_ok, "singular result with nonzero outputs")
  `LSV_ASSERT(a_lanes_aligned, clk, rst, lanes_ok, "divider lanes out of step")
  `LSV_ASSERT_ALWAYS(a_reset_empty, clk, rst || !$past(rst) || !rsp.valid, "valid after reset")

endmodule
